[src/two_pool_server_allocator_unit_assert.svh]
// Assertion macros for the two-pool server allocator checkers.
// Expects aclk and aresetn to exist in the module that uses them.
`ifndef TWO_POOL_SERVER_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_POOL_SERVER_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define TPSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TPSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tpsa_pkg.sv]
// Shared types and constants for the two-pool server allocator.
// Used by tpsa_cell, the top level and the port checker.
package tpsa_pkg;

    localparam int MAX_SERVERS = 64;
    localparam int SRV_W       = 6;
    localparam int CNT_W       = 7;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 24;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FAIL    = 2'd2
    } status_t;

    // One position of the ordered server list
    typedef struct packed {
        logic [SRV_W-1:0] id;
        logic             kind;
        logic             busy;
    } slot_t;

    // Search token walking the row of cells
    typedef struct packed {
        logic             valid;
        logic             s_busy;
        logic             s_kind;
        logic [SRV_W-1:0] s_pos;
        logic             have_want;
        logic [SRV_W-1:0] want_pos;
        logic [SRV_W-1:0] want_id;
        logic             have_other;
        logic [SRV_W-1:0] other_pos;
        logic [SRV_W-1:0] other_id;
    } token_t;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic             rebuild;
        logic [CNT_W-1:0] count;
        logic [SRV_W-1:0] scan_id;
        logic             scan_kind;
        logic             grant;
        logic [SRV_W-1:0] grant_pos;
        logic             grant_kind;
        logic             release_op;
        logic [SRV_W-1:0] rel_pos;
        logic [SRV_W-1:0] rel_id;
        logic             rel_kind;
    } cell_cmd_t;

endpackage

[src/tpsa_cell.sv]
// One position of the ordered server list plus one stage of the search token.
// Depends on tpsa_pkg.
module tpsa_cell
    import tpsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_cmd_t        cmd,
    input  logic [SRV_W-1:0] cell_pos,
    input  slot_t            up_slot,
    output slot_t            slot,
    input  token_t           tok_in,
    output token_t           tok_out
);

    slot_t            slot_reg, slot_next;
    token_t           tok_reg, tok_next;
    logic [CNT_W-1:0] pos_ext;
    logic             in_pool;
    logic             is_last;
    logic             above_rel;

    assign pos_ext   = {{(CNT_W-SRV_W){1'b0}}, cell_pos};
    assign in_pool   = pos_ext < cmd.count;
    assign is_last   = (pos_ext + CNT_W'(1)) == cmd.count;
    assign above_rel = cell_pos >= cmd.rel_pos;

    // Rebuild, retag on grant, or close the gap and append on release
    always_comb begin
        slot_next = slot_reg;
        if (cmd.rebuild) begin
            slot_next.id   = cell_pos;
            slot_next.kind = 1'b0;
            slot_next.busy = 1'b0;
        end else if (cmd.grant && (cell_pos == cmd.grant_pos)) begin
            slot_next.busy = 1'b1;
            slot_next.kind = cmd.grant_kind;
        end else if (cmd.release_op) begin
            if (is_last) begin
                slot_next.id   = cmd.rel_id;
                slot_next.kind = cmd.rel_kind;
                slot_next.busy = 1'b0;
            end else if (above_rel && in_pool) begin
                slot_next = up_slot;
            end
        end
    end

    // Fold this position into the passing token
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && in_pool) begin
            if (slot_reg.id == cmd.scan_id) begin
                tok_next.s_busy = slot_reg.busy;
                tok_next.s_kind = slot_reg.kind;
                tok_next.s_pos  = cell_pos;
            end
            if (!slot_reg.busy && !tok_in.have_want && (slot_reg.kind == cmd.scan_kind)) begin
                tok_next.have_want = 1'b1;
                tok_next.want_pos  = cell_pos;
                tok_next.want_id   = slot_reg.id;
            end
            if (!slot_reg.busy && !tok_in.have_other && (slot_reg.kind != cmd.scan_kind)) begin
                tok_next.have_other = 1'b1;
                tok_next.other_pos  = cell_pos;
                tok_next.other_id   = slot_reg.id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.id   <= cell_pos;
            slot_reg.kind <= 1'b0;
            slot_reg.busy <= 1'b0;
            tok_reg       <= '0;
        end else begin
            slot_reg <= slot_next;
            tok_reg  <= tok_next;
        end
    end

    assign slot    = slot_reg;
    assign tok_out = tok_reg;

endmodule

[src/two_pool_server_allocator_unit.sv]
// Top level of the two-pool server allocator: controller, row of list cells and stream ports.
// Depends on tpsa_pkg and tpsa_cell.
//
// The servers sit in a row of 64 cells that hold them as one ordered list;
// free servers appear in the order they were freed, so the first free one of a
// kind is the oldest. A request enters, a search token walks the row one cell
// per clock over the 64 cells, the finished token is collected, and the result
// is committed and registered; the controller then returns to idle and only
// there takes a new request. A waiting result does not stop the next request
// from being accepted, but the next result is held back until the waiting one is
// taken. A write of cfg_wr_data rebuilds the pool (all servers free, kind 0, in
// index order); a value of 0 acts as 1 and a value above 64 acts as 64.
module two_pool_server_allocator_unit
    import tpsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: server_index [5:0], kind_wanted [6], zero [7]
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: req_type [0]
    input  logic                s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m_tdata: granted_server [5:0], kind_one_count [12:6],
    //          kind_zero_count [19:13], zero [23:20]
    output logic [M_DATA_W-1:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [1:0]          m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      num_reg;
    logic [CNT_W-1:0]      k1_reg, k1_next;
    logic                  req_free_reg;
    logic [SRV_W-1:0]      req_id_reg;
    logic                  req_kind_reg;
    logic                  start_reg;
    token_t                fin_reg;
    logic                  m_valid_reg;
    logic [1:0]            m_user_reg;
    logic [M_DATA_W-1:0]   m_data_reg;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic [CNT_W-1:0]      cfg_clamped;
    token_t                start_tok;
    cell_cmd_t             cmd;
    slot_t                 slots [MAX_SERVERS];
    token_t                toks  [MAX_SERVERS+1];

    status_t               status;
    logic [SRV_W-1:0]      granted;
    logic                  do_grant, do_release;
    logic [SRV_W-1:0]      g_pos;
    logic [SRV_W-1:0]      g_id;
    logic                  old_kind;
    logic [CNT_W-1:0]      k0_next;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == S_DONE) && out_free;

    // Clamp the written pool size into range
    always_comb begin
        cfg_clamped = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (cfg_wr_data > CNT_W'(MAX_SERVERS)) begin
            cfg_clamped = CNT_W'(MAX_SERVERS);
        end
    end

    // Launch an empty token into the first cell
    always_comb begin
        start_tok       = '0;
        start_tok.valid = start_reg;
    end

    // Decide the outcome from the finished token
    always_comb begin
        status     = STAT_OK;
        granted    = '0;
        do_grant   = 1'b0;
        do_release = 1'b0;
        g_pos      = fin_reg.s_pos;
        g_id       = req_id_reg;
        old_kind   = fin_reg.s_kind;
        k1_next    = k1_reg;
        if ({1'b0, req_id_reg} >= num_reg) begin
            status = STAT_INVALID;
        end else if (req_free_reg) begin
            if (!fin_reg.s_busy) begin
                status = STAT_FAIL;
            end else begin
                do_release = 1'b1;
            end
        end else begin
            if (!fin_reg.s_busy) begin
                do_grant = 1'b1;
            end else if (fin_reg.have_want) begin
                do_grant = 1'b1;
                g_pos    = fin_reg.want_pos;
                g_id     = fin_reg.want_id;
                old_kind = req_kind_reg;
            end else if (fin_reg.have_other) begin
                do_grant = 1'b1;
                g_pos    = fin_reg.other_pos;
                g_id     = fin_reg.other_id;
                old_kind = !req_kind_reg;
            end else begin
                status = STAT_FAIL;
            end
            if (do_grant) begin
                granted = g_id;
                if (old_kind != req_kind_reg) begin
                    if (req_kind_reg) begin
                        k1_next = k1_reg + CNT_W'(1);
                    end else if (k1_reg != '0) begin
                        k1_next = k1_reg - CNT_W'(1);
                    end
                end
            end
        end
        k0_next = num_reg - k1_next;
    end

    // Broadcast command to the row
    always_comb begin
        cmd            = '0;
        cmd.rebuild    = cfg_wr_en;
        cmd.count      = num_reg;
        cmd.scan_id    = req_id_reg;
        cmd.scan_kind  = req_kind_reg;
        cmd.grant      = commit && do_grant;
        cmd.grant_pos  = g_pos;
        cmd.grant_kind = req_kind_reg;
        cmd.release_op = commit && do_release;
        cmd.rel_pos    = fin_reg.s_pos;
        cmd.rel_id     = req_id_reg;
        cmd.rel_kind   = fin_reg.s_kind;
    end

    // Row of list cells
    assign toks[0] = start_tok;
    for (genvar j = 0; j < MAX_SERVERS; j++) begin : g_cell
        slot_t up;
        if (j == MAX_SERVERS - 1) begin : g_top
            assign up = '0;
        end else begin : g_mid
            assign up = slots[j+1];
        end
        tpsa_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .cell_pos (SRV_W'(j)),
            .up_slot  (up),
            .slot     (slots[j]),
            .tok_in   (toks[j]),
            .tok_out  (toks[j+1])
        );
    end

    // Sequence one request at a time
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (toks[MAX_SERVERS].valid) state_next = S_DONE;
            end
            S_DONE: begin
                if (commit) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            num_reg     <= CNT_W'(MAX_SERVERS);
            k1_reg      <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_wr_en) begin
                num_reg <= cfg_clamped;
                k1_reg  <= '0;
            end else if (commit) begin
                k1_reg <= k1_next;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold request fields, the finished token and the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_free_reg <= s_tuser;
            req_id_reg   <= s_tdata[SRV_W-1:0];
            req_kind_reg <= s_tdata[SRV_W];
        end
        if (toks[MAX_SERVERS].valid) begin
            fin_reg <= toks[MAX_SERVERS];
        end
        if (commit) begin
            m_user_reg <= status;
            m_data_reg <= {{(M_DATA_W-SRV_W-2*CNT_W){1'b0}}, k0_next, k1_next, granted};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

[src/tpsa_checker.sv]
// Port-level checker for the two-pool server allocator, bound to the top level.
// Depends on tpsa_pkg and two_pool_server_allocator_unit_assert.svh.
`include "two_pool_server_allocator_unit_assert.svh"

module tpsa_checker
    import tpsa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                m_tvalid,
    input logic                m_tready
);

    // A stalled result holds
    `TPSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One request in flight: no accept right after an accept
    `TPSA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted while another is in flight")

    // Failed or invalid requests grant nothing
    `TPSA_ASSERT_SAME(a_err_no_grant, m_tvalid && (m_tuser != STAT_OK), m_tdata[5:0] == 6'd0, "grant reported on error status")

    // Status is a defined code
    `TPSA_ASSERT_SAME(a_status_code, m_tvalid, (m_tuser == STAT_OK) || (m_tuser == STAT_INVALID) || (m_tuser == STAT_FAIL), "undefined status code")

    // Kind counts add up to a legal pool size
    `TPSA_ASSERT_SAME(a_count_sum, m_tvalid, ((8'(m_tdata[12:6]) + 8'(m_tdata[19:13])) >= 8'd1) && ((8'(m_tdata[12:6]) + 8'(m_tdata[19:13])) <= 8'(MAX_SERVERS)), "kind counts out of range")

endmodule

bind two_pool_server_allocator_unit tpsa_checker u_tpsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
